>>> hdl/fmps_pkg.sv
// Shared types, constants and a helper function of the first-match pattern search.
package fmps_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned MAX_PATTERN_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LENGTH_W      = 5;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned PATTERN_BYTES = 16;
  localparam int unsigned PATTERN_W     = PATTERN_BYTES * BYTE_W;
  localparam int unsigned OFFSET_W      = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CASE_SENSITIVE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd3;

  // ASCII letter bounds used by case folding.
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_DIFF    = CHAR_LOWER_A - CHAR_UPPER_A;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [LENGTH_W-1:0]  pattern_length;
    logic                 case_sensitive;
    logic [PATTERN_W-1:0] pattern;
  } cfg_t;

  // Maps an upper-case ASCII letter to lower case and leaves other bytes alone.
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_DIFF;
    end
    return r;
  endfunction

endpackage

>>> hdl/fmps_cfg.sv
// Configuration registers of the pattern search, written through a plain write port.
module fmps_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fmps_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [fmps_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output fmps_pkg::cfg_t                        cfg_o
);
  import fmps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_LENGTH: cfg_d.pattern_length = cfg_data_i[LENGTH_W-1:0];
        CFG_CASE_SENSITIVE: cfg_d.case_sensitive = cfg_data_i[0];
        CFG_PATTERN_LOW:    cfg_d.pattern[CFG_DATA_W-1:0] = cfg_data_i;
        CFG_PATTERN_HIGH:   cfg_d.pattern[PATTERN_W-1:CFG_DATA_W] = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= '0;
      cfg_q.case_sensitive <= 1'b1;
      cfg_q.pattern        <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/fmps_match.sv
// Window of recent bytes and the parallel comparison against the pattern.
module fmps_match #(
  parameter int unsigned MAX_PATTERN = fmps_pkg::MAX_PATTERN_DEF,
  parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic [fmps_pkg::BYTE_W-1:0]   cur_byte_i,
  input  fmps_pkg::cfg_t                cfg_i,
  output logic [LEN_W-1:0]              eff_len_o,
  output logic                          all_match_o
);
  import fmps_pkg::*;

  localparam int unsigned WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [BYTE_W-1:0] win_q [WIN_D];
  logic [BYTE_W-1:0] seq   [MAX_PATTERN];
  logic [LEN_W-1:0]  eff_len;

  // Shift line: entry 0 holds the newest byte before the current one.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q[0] <= cur_byte_i;
      for (int i = 1; i < WIN_D; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  // seq[j] is the byte j places back from the current one.
  assign seq[0] = cur_byte_i;
  for (genvar j = 1; j < MAX_PATTERN; j++) begin : g_seq
    assign seq[j] = win_q[j-1];
  end

  // Lengths beyond the pattern store are cut to its size.
  always_comb begin
    if (cfg_i.pattern_length > LENGTH_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(cfg_i.pattern_length);
    end
  end

  // Pattern byte k lines up with the byte (len - 1 - k) places back.
  always_comb begin
    logic [LEN_W-1:0]  age;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] p;
    all_match_o = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      age = eff_len - LEN_W'(1) - LEN_W'(k);
      b   = seq[age[IDX_W-1:0]];
      p   = cfg_i.pattern[BYTE_W*k +: BYTE_W];
      if (!cfg_i.case_sensitive) begin
        b = fold_case(b);
        p = fold_case(p);
      end
      if (LEN_W'(k) < eff_len && b != p) begin
        all_match_o = 1'b0;
      end
    end
  end

  assign eff_len_o = eff_len;

endmodule

>>> hdl/first_match_pattern_search.sv
// Top level of the first-match pattern search over a byte stream.
// A result is computed from the byte in the input register and loaded into the result
// register when that byte leaves the input stage; found_o and match_offset_o come from it.
// Throughput: one byte per cycle; all pattern comparisons run in parallel between the
// input register and the result register, so the input stalls only when the result waits.
// Reset: control state clears, pattern_length resets to 0, case_sensitive to 1, pattern to 0.
module first_match_pattern_search #(
  parameter int unsigned MAX_PATTERN   = fmps_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = fmps_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [fmps_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [fmps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input channel: one byte of the searched buffer per item.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [fmps_pkg::BYTE_W-1:0]        data_byte_i,
  input  logic                               end_of_buffer_i,
  // Result channel: at most one item per buffer.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               found_o,
  output logic [fmps_pkg::OFFSET_W-1:0]      match_offset_o
);
  import fmps_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PW1   = POSITION_BITS + 1;
  localparam int unsigned OFF_W = (PW1 > OFFSET_W + 1) ? PW1 : OFFSET_W + 1;

  cfg_t cfg;

  // Input register stage.
  logic              s1_valid_q, s1_valid_d;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_last_q;

  // Per-buffer state.
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     reported_q, reported_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic                found_q, found_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;

  logic             accept_in;
  logic             advance;
  logic [LEN_W-1:0] eff_len;
  logic             all_match;
  logic             enough;
  logic             hit;
  logic             emit;
  logic [PW1-1:0]   pos_p1;
  logic [PW1-1:0]   off_raw;
  logic [OFF_W-1:0] off_wide;
  logic [OFFSET_W-1:0] off_sat;

  fmps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The window shifts on every byte that leaves the input stage, except a buffer's
  // last byte: after it the position is zero, so stale entries are never looked at.
  fmps_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk_i       (clk_i),
    .shift_i     (advance && !s1_last_q),
    .cur_byte_i  (s1_byte_q),
    .cfg_i       (cfg),
    .eff_len_o   (eff_len),
    .all_match_o (all_match)
  );

  // The byte in the input stage moves on whenever the result register is free or
  // being emptied in the same cycle; a new item may enter behind it at once.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept_in  = in_valid_i && !in_stall_o;

  // A match needs at least pattern-length bytes of this buffer, counting the current one.
  assign pos_p1 = PW1'(pos_q) + PW1'(1);
  assign enough = pos_p1 >= PW1'(eff_len);
  assign hit    = enough && all_match;
  assign emit   = !reported_q && (hit || s1_last_q);

  // Offset of the first matching byte; an empty pattern matches at the current position.
  always_comb begin
    if (eff_len == '0) begin
      off_raw = PW1'(pos_q);
    end else begin
      off_raw = pos_p1 - PW1'(eff_len);
    end
    off_wide = OFF_W'(off_raw);
    if (off_wide[OFF_W-1:OFFSET_W] != '0) begin
      off_sat = '1;
    end else begin
      off_sat = off_wide[OFFSET_W-1:0];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_in) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // The position counter saturates; a buffer's last byte clears it for the next buffer.
  always_comb begin
    pos_d      = pos_q;
    reported_d = reported_q;
    if (advance) begin
      if (s1_last_q) begin
        pos_d      = '0;
        reported_d = 1'b0;
      end else begin
        if (pos_q != '1) begin
          pos_d = pos_q + POSITION_BITS'(1);
        end
        if (emit) begin
          reported_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    offset_d    = offset_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
      found_d     = hit;
      offset_d    = hit ? off_sat : '0;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pos_q       <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pos_q       <= pos_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= end_of_buffer_i;
    end
    found_q  <= found_d;
    offset_q <= offset_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the first-match pattern search: directed cases, then random buffers.
module tb;
  import fmps_pkg::*;

  // The window holds the bytes before the current one, so the longest usable pattern is one more.
  localparam int unsigned WINDOW         = 15;
  localparam int unsigned LONGEST        = MAX_PATTERN_DEF;
  localparam int unsigned POS_W          = POSITION_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RANDOM_ITEMS   = 540;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned FILLER_BYTES   = 100;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } search_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [BYTE_W-1:0]      data_byte_i;
  logic                   end_of_buffer_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   found_o;
  logic [OFFSET_W-1:0]    match_offset_o;

  first_match_pattern_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_buffer_i(end_of_buffer_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o)
  );

  // Our own copy of the configuration registers, updated as each write lands.
  logic [LENGTH_W-1:0]  model_length;
  logic                 model_exact;
  logic [PATTERN_W-1:0] model_pattern;

  // Our own copy of the per-buffer search state; history[0] is the newest earlier byte.
  logic [BYTE_W-1:0]    history [WINDOW];
  logic [POS_W-1:0]     bytes_seen;
  logic                 already_found;

  // Results that the block owes us, oldest first.
  search_result_t       pending_results [$];
  search_result_t       oldest;

  // The bytes of the buffer that is sent next.
  logic [BYTE_W-1:0]    buffer_bytes [$];

  // Idling controls: both sides pause in random bursts while these are set.
  logic                 input_gaps;
  logic                 output_stalls;

  int unsigned          mismatch_count;
  int unsigned          items_sent;
  int unsigned          buffers_sent;
  int unsigned          results_seen;
  int unsigned          matches_seen;
  int unsigned          idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Prints one line per mismatch (the first few only) and counts every one of them.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 30) begin
      $display("%0t: mismatch in %s: got %0h, wanted %0h", $time, what, got, want);
    end
  endtask

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic void forget_buffer();
    int i;
    for (i = 0; i < WINDOW; i++) begin
      history[i] = '0;
    end
    bytes_seen    = '0;
    already_found = 1'b0;
  endfunction

  // Works out what one accepted byte causes and advances the search state.
  function automatic void search_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned    span;
    int unsigned    reach;
    int unsigned    start;
    int unsigned    k;
    int unsigned    age;
    int             i;
    logic           hit;
    logic [BYTE_W-1:0] seen_b;
    logic [BYTE_W-1:0] pat_b;
    search_result_t r;
    if (!already_found) begin
      // A programmed length beyond the longest pattern is treated as the longest.
      span  = (model_length > LONGEST) ? LONGEST : model_length;
      reach = bytes_seen;
      reach = reach + 1;
      // No match is possible before the buffer holds at least a pattern's worth of bytes.
      hit = (reach >= span);
      for (k = 0; k < span && hit; k++) begin
        age    = span - 1 - k;
        seen_b = (age == 0) ? b : history[age - 1];
        pat_b  = model_pattern[8*k +: 8];
        if (!model_exact) begin
          seen_b = to_lower(seen_b);
          pat_b  = to_lower(pat_b);
        end
        if (seen_b != pat_b) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        // An empty pattern matches on the first byte; the offset is clamped to 16 bits.
        start = (span == 0) ? bytes_seen : reach - span;
        if (start > 32'hFFFF) begin
          start = 32'hFFFF;
        end
        r.found       = 1'b1;
        r.offset      = start[OFFSET_W-1:0];
        already_found = 1'b1;
        pending_results.push_back(r);
      end else if (last) begin
        r.found  = 1'b0;
        r.offset = '0;
        pending_results.push_back(r);
      end
    end
    if (last) begin
      forget_buffer();
    end else begin
      for (i = WINDOW - 1; i > 0; i--) begin
        history[i] = history[i - 1];
      end
      history[0] = b;
      // The position counter sticks at its all-ones value on very long buffers.
      if (bytes_seen != '1) begin
        bytes_seen = bytes_seen + 1'b1;
      end
    end
  endfunction

  // Register writes happen only while the block is idle; the model follows each one.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_PATTERN_LENGTH: model_length = data[LENGTH_W-1:0];
      CFG_CASE_SENSITIVE: model_exact = data[0];
      CFG_PATTERN_LOW:    model_pattern[CFG_DATA_W-1:0] = data;
      CFG_PATTERN_HIGH:   model_pattern[PATTERN_W-1:CFG_DATA_W] = data;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] length, input logic exact,
                           input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] high);
    write_reg(CFG_PATTERN_LENGTH, length);
    write_reg(CFG_CASE_SENSITIVE, {{(CFG_DATA_W-1){1'b0}}, exact});
    write_reg(CFG_PATTERN_LOW, low);
    write_reg(CFG_PATTERN_HIGH, high);
  endtask

  // Offers one item and holds it until the block takes it; prediction happens on acceptance.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (input_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_buffer_i <= last;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    search_byte(b, last);
    items_sent++;
  endtask

  task automatic send_buffer();
    int i;
    for (i = 0; i < buffer_bytes.size(); i++) begin
      send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
    end
    buffers_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    buffer_bytes.delete();
    for (i = 0; i < s.len(); i++) begin
      buffer_bytes.push_back(s[i]);
    end
    send_buffer();
  endtask

  // Packs up to eight characters into a pattern register, first character lowest.
  function automatic logic [CFG_DATA_W-1:0] pack_text(input string s);
    logic [CFG_DATA_W-1:0] w;
    int i;
    w = '0;
    for (i = 0; i < s.len() && i < 8; i++) begin
      w[8*i +: 8] = s[i];
    end
    return w;
  endfunction

  // Drops valid, waits for every owed result, then lets the block go quiet before returning,
  // since a byte that causes no result may still be in flight when the last result arrives.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Bytes are drawn mostly from a few letters and the bytes either side of the letter ranges,
  // so that partial matches and case folding come up often.
  function automatic logic [BYTE_W-1:0] random_symbol();
    logic [BYTE_W-1:0] c;
    case ($urandom_range(0, 3))
      0: c = $urandom_range(0, 255);
      1: c = CHAR_LOWER_A + $urandom_range(0, 2);
      2: c = CHAR_UPPER_A + $urandom_range(0, 2);
      default: begin
        case ($urandom_range(0, 3))
          0: c = CHAR_UPPER_A - 1;
          1: c = CHAR_UPPER_Z + 1;
          2: c = CHAR_LOWER_A - 1;
          default: c = CHAR_LOWER_Z + 1;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_pattern_word();
    logic [CFG_DATA_W-1:0] w;
    int i;
    for (i = 0; i < 8; i++) begin
      w[8*i +: 8] = random_symbol();
    end
    return w;
  endfunction

  // Copies pattern bytes into the buffer, flipping the case of some letters at random when folding is on.
  function automatic void plant_pattern(input int unsigned pos, input int unsigned count);
    logic [BYTE_W-1:0] c;
    int unsigned k;
    for (k = 0; k < count; k++) begin
      c = model_pattern[8*k +: 8];
      if (!model_exact && (c & 8'hDF) >= CHAR_UPPER_A && (c & 8'hDF) <= CHAR_UPPER_Z &&
          $urandom_range(0, 1) == 1) begin
        c = c ^ 8'h20;
      end
      buffer_bytes[pos + k] = c;
    end
  endfunction

  // Mostly buffers that carry the pattern somewhere, some with one bit spoilt, some cut off
  // part way through the pattern, and the rest plain noise.
  function automatic void build_random_buffer();
    int unsigned span;
    int unsigned size;
    int unsigned kind;
    int unsigned pos;
    int unsigned i;
    span = (model_length > LONGEST) ? LONGEST : model_length;
    size = $urandom_range(1, span + 12);
    kind = $urandom_range(0, 9);
    buffer_bytes.delete();
    for (i = 0; i < size; i++) begin
      buffer_bytes.push_back(random_symbol());
    end
    if (kind < 7 && span > 0 && span <= size) begin
      pos = $urandom_range(0, size - span);
      plant_pattern(pos, span);
      if (kind == 6) begin
        pos = pos + $urandom_range(0, span - 1);
        buffer_bytes[pos] = buffer_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else if (kind == 7 && span > 1 && span <= size) begin
      plant_pattern(size - span + 1, span - 1);
    end
  endfunction

  // After reset the pattern is empty, which matches at offset 0 on every buffer's first byte.
  task automatic test_reset_defaults();
    buffer_bytes.delete();
    buffer_bytes.push_back(8'h00);
    buffer_bytes.push_back(8'hFF);
    buffer_bytes.push_back(8'h41);
    send_buffer();
    send_text("z");
    settle();
  endtask

  // Exact compare: first match only, match at the very start, buffer too short, case mismatch.
  task automatic test_exact_match();
    configure(3, 1'b1, pack_text("abc"), '0);
    send_text("xxabcabc");
    send_text("abc");
    send_text("ab");
    send_text("aBc");
    settle();
  endtask

  // Folding covers letters only; the bytes just outside the letter ranges must match exactly.
  task automatic test_case_folding();
    configure(4, 1'b0, pack_text("Az@["), '0);
    send_text("aZ@[");
    send_text("xAZ`{");
    send_text("qqaz@[");
    settle();
    write_reg(CFG_CASE_SENSITIVE, '0 | 1'b1);
    send_text("aZ@[");
    send_text("Az@[");
    settle();
  endtask

  // Full sixteen-byte pattern using both registers, the extreme byte values and the clamp
  // of an oversized length; a spoilt oldest byte checks the far end of the window.
  task automatic test_full_length();
    int k;
    configure(16, 1'b1, 64'h807F_00FF_55AA_01FE, 64'hFF00_4161_5A7A_0080);
    buffer_bytes.delete();
    for (k = 0; k < LONGEST; k++) begin
      buffer_bytes.push_back(model_pattern[8*k +: 8]);
    end
    send_buffer();
    void'(buffer_bytes.pop_back());
    send_buffer();
    settle();
    write_reg(CFG_PATTERN_LENGTH, 31);
    buffer_bytes.delete();
    buffer_bytes.push_back(8'h11);
    buffer_bytes.push_back(8'h22);
    for (k = 0; k < LONGEST; k++) begin
      buffer_bytes.push_back(model_pattern[8*k +: 8]);
    end
    send_buffer();
    buffer_bytes[2] = buffer_bytes[2] ^ 8'h80;
    send_buffer();
    settle();
    write_reg(CFG_PATTERN_LENGTH, 17);
    buffer_bytes[2] = buffer_bytes[2] ^ 8'h80;
    send_buffer();
    settle();
  endtask

  // A long buffer whose match lies well past its start, at an offset of FILLER_BYTES;
  // the next buffer must start again from offset 0.
  task automatic test_long_buffer();
    int i;
    configure(2, 1'b1, 64'h0000_0000_0000_FEFF, '0);
    for (i = 0; i < FILLER_BYTES; i++) begin
      send_byte(8'h00, 1'b0);
    end
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b1);
    buffers_sent++;
    buffer_bytes.delete();
    buffer_bytes.push_back(8'hFF);
    buffer_bytes.push_back(8'hFE);
    send_buffer();
    settle();
  endtask

  // Random buffers under several settings; the last phase runs without any idling.
  task automatic test_random_buffers();
    int unsigned phase;
    int unsigned phase_start;
    logic [CFG_DATA_W-1:0] length;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: length = 0;
        1: length = 1;
        2: length = LONGEST;
        3: length = 31;
        4: length = $urandom_range(2, 6);
        default: length = $urandom_range(1, LONGEST);
      endcase
      settle();
      configure(length, phase[0], random_pattern_word(), random_pattern_word());
      if (phase == RANDOM_PHASES - 1) begin
        input_gaps    = 1'b0;
        output_stalls = 1'b0;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / RANDOM_PHASES) begin
        build_random_buffer();
        send_buffer();
      end
    end
    settle();
  endtask

  // The result side stalls in random bursts while stalls are enabled.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (output_stalls && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Each accepted result is compared with the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing owed", {found_o, match_offset_o}, '0);
      end else begin
        oldest = pending_results.pop_front();
        if (found_o !== oldest.found) begin
          report_mismatch("found", found_o, oldest.found);
        end
        if (match_offset_o !== oldest.offset) begin
          report_mismatch("match_offset", match_offset_o, oldest.offset);
        end
        if (oldest.found) begin
          matches_seen++;
        end
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    mismatch_count  = 0;
    items_sent      = 0;
    buffers_sent    = 0;
    results_seen    = 0;
    matches_seen    = 0;
    input_gaps      = 1'b1;
    output_stalls   = 1'b1;
    model_length    = '0;
    model_exact     = 1'b1;
    model_pattern   = '0;
    forget_buffer();
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= CFG_PATTERN_LENGTH;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    data_byte_i     <= '0;
    end_of_buffer_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_exact_match();
    test_case_folding();
    test_full_length();
    test_long_buffer();
    test_random_buffers();

    if (pending_results.size() != 0) begin
      report_mismatch("results still owed at the end", 0, pending_results.size());
    end
    $display("Searched %0d buffers (%0d bytes); %0d results came back, %0d of them matches.",
             buffers_sent, items_sent, results_seen, matches_seen);
    $display("Pattern lengths 0 to 31 in both case modes, including a long buffer.");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/fmps_pkg.sv
hdl/fmps_cfg.sv
hdl/fmps_match.sv
hdl/first_match_pattern_search.sv
tb/tb.sv
